// ===== hw/rtl/ovab_pkg.sv =====
`default_nettype none
package ovab_pkg;

    // field widths fixed by the pixel and register formats
    localparam int CH_W       = 8;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SCALE_W    = 24;
    localparam int OVL_DIM_W  = 9;
    localparam int OUT_DIM_W  = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVL_W   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVL_H   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_W   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_H   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd6;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    typedef struct packed {
        logic                 enable;
        logic [OVL_DIM_W-1:0] ovl_w;
        logic [OVL_DIM_W-1:0] ovl_h;
        logic [OUT_DIM_W-1:0] out_w;
        logic [OUT_DIM_W-1:0] out_h;
        logic [SCALE_W-1:0]   scale_x;
        logic [SCALE_W-1:0]   scale_y;
    } t_cfg;

    // exact x / 255 for any x up to 255 * 255
    function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ovab_cfg_if.sv =====
`default_nettype none
interface ovab_cfg_if import ovab_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ovab_pix_if.sv =====
`default_nettype none
interface ovab_pix_if import ovab_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [CH_W-1:0]  red_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  blue_in;
    logic [CH_W-1:0]  alpha_in;

    modport source (output valid, output opcode, output pos_x, output pos_y,
                    output red_in, output green_in, output blue_in, output alpha_in,
                    input ready);
    modport sink   (input valid, input opcode, input pos_x, input pos_y,
                    input red_in, input green_in, input blue_in, input alpha_in,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ovab_res_if.sv =====
`default_nettype none
interface ovab_res_if import ovab_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ovab_front.sv =====
`default_nettype none
module ovab_front import ovab_pkg::*; #(
    parameter int MAX_OVL_WIDTH  = 256,
    parameter int MAX_OVL_HEIGHT = 256,
    parameter int FRAC_BITS      = 16,
    parameter int ENTRY_W        = 4 + 2*8 + 2*8 + 2*16 + 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    input  wire logic               i_opcode,
    input  wire logic [POS_W-1:0]   i_pos_x,
    input  wire logic [POS_W-1:0]   i_pos_y,
    input  wire logic [CH_W-1:0]    i_red,
    input  wire logic [CH_W-1:0]    i_green,
    input  wire logic [CH_W-1:0]    i_blue,
    input  wire logic [CH_W-1:0]    i_alpha,
    output logic                    o_ready,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [ENTRY_W-1:0]      o_entry
);
    localparam int XW   = $clog2(MAX_OVL_WIDTH);
    localparam int YW   = $clog2(MAX_OVL_HEIGHT);
    localparam int OWW  = $clog2(MAX_OVL_WIDTH + 1);
    localparam int OHW  = $clog2(MAX_OVL_HEIGHT + 1);
    localparam int QW   = POS_W + SCALE_W;
    // reciprocal of the store row length, exact for any 12-bit column
    localparam int DK   = POS_W + XW + 1;
    localparam int DM   = ((1 << DK) + MAX_OVL_WIDTH - 1) / MAX_OVL_WIDTH;
    localparam int DMW  = $clog2(DM + 1);

    typedef struct packed {
        logic                 vid;
        logic                 wr;
        logic                 blend;
        logic                 zero;
        logic [XW-1:0]        x0;
        logic [XW-1:0]        x1;
        logic [YW-1:0]        y0;
        logic [YW-1:0]        y1;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic [CH_W-1:0]      alpha;
    } t_entry;

    logic en;
    logic r_s1_v, r_s2_v;

    logic             r_s1_op;
    logic [POS_W-1:0] r_s1_px, r_s1_py;
    logic [CH_W-1:0]  r_s1_r, r_s1_g, r_s1_b, r_s1_a;
    logic             r_s1_blend, r_s1_eq;
    logic [QW-1:0]    r_s1_qx, r_s1_qy;
    logic [POS_W-1:0] r_s1_q;
    t_entry           r_s2;

    logic [POS_W+DMW-1:0] dprod, dshift;

    assign en      = !r_s2_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_s2_v;
    assign o_entry = ENTRY_W'(r_s2);

    assign dprod  = (POS_W+DMW)'(i_pos_x) * (POS_W+DMW)'(DM);
    assign dshift = dprod >> DK;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
        end
    end

    // stage one: classify and scale the position
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op    <= i_opcode;
            r_s1_px    <= i_pos_x;
            r_s1_py    <= i_pos_y;
            r_s1_r     <= i_red;
            r_s1_g     <= i_green;
            r_s1_b     <= i_blue;
            r_s1_a     <= i_alpha;
            r_s1_blend <= i_cfg.enable && ({1'b0, i_pos_x} < i_cfg.out_w)
                          && ({1'b0, i_pos_y} < i_cfg.out_h);
            r_s1_eq    <= ({4'd0, i_cfg.ovl_w} == i_cfg.out_w)
                          && ({4'd0, i_cfg.ovl_h} == i_cfg.out_h);
            r_s1_qx    <= QW'(i_pos_x) * QW'(i_cfg.scale_x);
            r_s1_qy    <= QW'(i_pos_y) * QW'(i_cfg.scale_y);
            r_s1_q     <= dshift[POS_W-1:0];
        end
    end

    // stage two: neighbour coordinates
    logic [OWW-1:0]   ow;
    logic [OHW-1:0]   oh;
    logic [XW-1:0]    ow_m1, bx0, bx1;
    logic [YW-1:0]    oh_m1, by0, by1;
    logic [QW-1:0]    ix, iy;
    logic [POS_W-1:0] rem;
    logic [POS_W:0]   ye;
    t_entry           nx;

    always_comb begin
        if (i_cfg.ovl_w == '0)
            ow = OWW'(1);
        else if (32'(i_cfg.ovl_w) > MAX_OVL_WIDTH)
            ow = OWW'(MAX_OVL_WIDTH);
        else
            ow = OWW'(i_cfg.ovl_w);
        if (i_cfg.ovl_h == '0)
            oh = OHW'(1);
        else if (32'(i_cfg.ovl_h) > MAX_OVL_HEIGHT)
            oh = OHW'(MAX_OVL_HEIGHT);
        else
            oh = OHW'(i_cfg.ovl_h);
        ow_m1 = XW'(ow - OWW'(1));
        oh_m1 = YW'(oh - OHW'(1));

        ix  = r_s1_qx >> FRAC_BITS;
        iy  = r_s1_qy >> FRAC_BITS;
        bx0 = (ix > QW'(ow_m1)) ? ow_m1 : ix[XW-1:0];
        by0 = (iy > QW'(oh_m1)) ? oh_m1 : iy[YW-1:0];
        bx1 = (bx0 == ow_m1) ? ow_m1 : bx0 + XW'(1);
        by1 = (by0 == oh_m1) ? oh_m1 : by0 + YW'(1);

        // same-size case: linear store index wraps into later rows
        rem = POS_W'(32'(r_s1_px) - 32'(r_s1_q) * MAX_OVL_WIDTH);
        ye  = {1'b0, r_s1_py} + {1'b0, r_s1_q};

        nx       = '0;
        nx.vid   = (r_s1_op == OP_BLEND);
        nx.blend = r_s1_blend;
        nx.red   = r_s1_r;
        nx.green = r_s1_g;
        nx.blue  = r_s1_b;
        nx.alpha = r_s1_a;
        if (r_s1_op == OP_WRITE) begin
            nx.wr = ({1'b0, r_s1_px} < (POS_W+1)'(MAX_OVL_WIDTH))
                    && ({1'b0, r_s1_py} < (POS_W+1)'(MAX_OVL_HEIGHT));
            nx.x0 = r_s1_px[XW-1:0];
            nx.x1 = r_s1_px[XW-1:0];
            nx.y0 = r_s1_py[YW-1:0];
            nx.y1 = r_s1_py[YW-1:0];
        end else if (r_s1_eq) begin
            nx.zero = (32'(ye) >= MAX_OVL_HEIGHT);
            nx.x0   = rem[XW-1:0];
            nx.x1   = rem[XW-1:0];
            nx.y0   = ye[YW-1:0];
            nx.y1   = ye[YW-1:0];
        end else begin
            nx.x0 = bx0;
            nx.x1 = bx1;
            nx.y0 = by0;
            nx.y1 = by1;
            nx.fx = r_s1_qx[FRAC_BITS-1:0];
            nx.fy = r_s1_qy[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2 <= nx;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ovab_queue.sv =====
`default_nettype none
module ovab_queue #(
    parameter int WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_head, r_tail;
    logic [CW-1:0]    r_count;
    logic             push, pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_head];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (push) r_tail <= r_tail + PW'(1);
            if (pop)  r_head <= r_head + PW'(1);
            r_count <= r_count + CW'(push) - CW'(pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_tail] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(DEPTH)) |-> !push)
        else $error("queue written while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !pop)
        else $error("queue read while empty");
    a_level_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue level lost a beat");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ovab_back.sv =====
`default_nettype none
module ovab_back import ovab_pkg::*; #(
    parameter int MAX_OVL_WIDTH  = 256,
    parameter int MAX_OVL_HEIGHT = 256,
    parameter int FRAC_BITS      = 16,
    parameter int ENTRY_W        = 4 + 2*8 + 2*8 + 2*16 + 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [ENTRY_W-1:0] i_entry,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [CH_W-1:0]         o_red,
    output logic [CH_W-1:0]         o_green,
    output logic [CH_W-1:0]         o_blue
);
    localparam int XW   = $clog2(MAX_OVL_WIDTH);
    localparam int YW   = $clog2(MAX_OVL_HEIGHT);
    localparam int WH   = (MAX_OVL_WIDTH + 1) / 2;
    localparam int HH   = (MAX_OVL_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = WH * HH;
    localparam int AW   = $clog2(BANK_DEPTH);
    localparam int WW   = 2*FRAC_BITS + 2;
    localparam int PW   = CH_W + WW;
    localparam int SW   = PW + 3;

    typedef struct packed {
        logic                 vid;
        logic                 wr;
        logic                 blend;
        logic                 zero;
        logic [XW-1:0]        x0;
        logic [XW-1:0]        x1;
        logic [YW-1:0]        y0;
        logic [YW-1:0]        y1;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic [CH_W-1:0]      alpha;
    } t_entry;

    t_entry h;
    logic   en;
    logic   r_v1, r_v2, r_v3, r_v4, r_v5;

    assign h       = t_entry'(i_entry);
    assign en      = !r_v5 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid && h.vid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // four banks split by column and row parity: one read each per beat
    logic [AW-1:0] addr [4];
    logic [31:0]   r_rd [4];
    logic [1:0]    wbank;

    assign wbank = {h.y0[0], h.x0[0]};

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [31:0]   r_store [BANK_DEPTH];
        logic [XW-1:0] xb;
        logic [YW-1:0] yb;

        assign xb = (h.x0[0] == b[0]) ? h.x0 : h.x1;
        assign yb = (h.y0[0] == b[1]) ? h.y0 : h.y1;
        assign addr[b] = AW'(32'(yb >> 1) * WH + 32'(xb >> 1));

        always_ff @(posedge i_clk) begin
            if (en && i_valid && h.wr && (wbank == 2'(b))) begin
                r_store[addr[b]] <= {h.alpha, h.blue, h.green, h.red};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rd[b] <= r_store[addr[b]];
            end
        end
    end

    // stage one: weights and neighbour bank selects
    logic [FRAC_BITS:0] omx, omy;
    logic [WW-1:0]      r_w [4];
    logic [1:0]         r_sel [4];
    logic               r_b1_blend, r_b1_zero;
    logic [CH_W-1:0]    r_b1_v [3];

    assign omx = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, h.fx};
    assign omy = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, h.fy};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w[0]     <= WW'(omx) * WW'(omy);
            r_w[1]     <= WW'(h.fx) * WW'(omy);
            r_w[2]     <= WW'(omx) * WW'(h.fy);
            r_w[3]     <= WW'(h.fx) * WW'(h.fy);
            r_sel[0]   <= {h.y0[0], h.x0[0]};
            r_sel[1]   <= {h.y0[0], h.x1[0]};
            r_sel[2]   <= {h.y1[0], h.x0[0]};
            r_sel[3]   <= {h.y1[0], h.x1[0]};
            r_b1_blend <= h.blend;
            r_b1_zero  <= h.zero;
            r_b1_v[0]  <= h.red;
            r_b1_v[1]  <= h.green;
            r_b1_v[2]  <= h.blue;
        end
    end

    // stage two: channel times weight for each neighbour
    logic [PW-1:0]   r_pr [4][4];
    logic            r_b2_blend;
    logic [CH_W-1:0] r_b2_v [3];
    logic [31:0]     px [4];

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            px[n] = r_b1_zero ? 32'd0 : r_rd[r_sel[n]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                for (int n = 0; n < 4; n++) begin
                    r_pr[k][n] <= PW'(px[n][8*k +: 8]) * PW'(r_w[n]);
                end
            end
            r_b2_blend <= r_b1_blend;
            r_b2_v     <= r_b1_v;
        end
    end

    // stage three: sum, round to nearest, saturate
    logic [SW-1:0]   acc [4];
    logic [SW-1:0]   shr [4];
    logic [CH_W-1:0] r_s [4];
    logic            r_b3_blend;
    logic [CH_W-1:0] r_b3_v [3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            acc[k] = SW'(r_pr[k][0]) + SW'(r_pr[k][1]) + SW'(r_pr[k][2])
                     + SW'(r_pr[k][3]) + (SW'(1) << (2*FRAC_BITS - 1));
            shr[k] = acc[k] >> (2*FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_s[k] <= (shr[k] > SW'(255)) ? 8'd255 : shr[k][CH_W-1:0];
            end
            r_b3_blend <= r_b2_blend;
            r_b3_v     <= r_b2_v;
        end
    end

    // stage four: weighted mix of video and overlay
    logic [15:0]     r_mix [3];
    logic [CH_W-1:0] r_b4_v [3];
    logic [CH_W-1:0] r_b4_s [3];
    logic [CH_W-1:0] r_b4_a;
    logic            r_b4_blend;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_mix[k] <= 16'(r_b3_v[k]) * 16'(8'd255 - r_s[3]) + 16'(r_s[k]) * 16'(r_s[3]);
                r_b4_s[k] <= r_s[k];
            end
            r_b4_v     <= r_b3_v;
            r_b4_a     <= r_s[3];
            r_b4_blend <= r_b3_blend;
        end
    end

    // stage five: output register
    logic [CH_W-1:0] res [3];
    logic [CH_W-1:0] r_out [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!r_b4_blend || r_b4_a == '0)
                res[k] = r_b4_v[k];
            else if (r_b4_a == 8'd255)
                res[k] = r_b4_s[k];
            else
                res[k] = div255(r_mix[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= res;
        end
    end

    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule
`default_nettype wire

// ===== hw/rtl/overlay_bilinear_alpha_blend_top.sv =====
`default_nettype none
// Overlay alpha blend with bilinear scaling of an RGBA overlay store.
// Channels: i_cfg writes the seven registers (index, data; always ready),
// i_pix carries overlay writes (opcode 0) and video pixels (opcode 1),
// o_res returns one RGB beat per video pixel and none per overlay write.
// The host fills every overlay entry it will sample before sending video;
// the store has no reset and no clearing pass, its contents are unknown
// until written. Registers must be changed only while the block is idle;
// the block itself does not enforce this. Throughput: one beat per cycle
// while o_res is not stalled. The store is split into four banks by
// column and row parity, so all four bilinear neighbours are read in the
// same cycle; the blend is a five-stage pipeline. A video pixel passes
// two front stages, the queue and five back stages on its way to o_res.
// When o_res stalls, the back pipeline holds, the four-entry queue fills,
// and then i_pix.ready drops until the receiver takes the waiting beat.
// Reset (i_rst_n low, synchronous) empties the pipeline and queue and
// restores the register defaults.
module overlay_bilinear_alpha_blend_top import ovab_pkg::*; #(
    parameter int MAX_OVL_WIDTH  = 256,
    parameter int MAX_OVL_HEIGHT = 256,
    parameter int FRAC_BITS      = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ovab_cfg_if.sink    i_cfg,
    ovab_pix_if.sink    i_pix,
    ovab_res_if.source  o_res
);
    localparam int XW      = $clog2(MAX_OVL_WIDTH);
    localparam int YW      = $clog2(MAX_OVL_HEIGHT);
    localparam int ENTRY_W = 4 + 2*XW + 2*YW + 2*FRAC_BITS + 4*CH_W;

    t_cfg r_cfg;

    // register file
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable  <= 1'b0;
            r_cfg.ovl_w   <= OVL_DIM_W'(256);
            r_cfg.ovl_h   <= OVL_DIM_W'(256);
            r_cfg.out_w   <= OUT_DIM_W'(256);
            r_cfg.out_h   <= OUT_DIM_W'(256);
            r_cfg.scale_x <= SCALE_W'(65536);
            r_cfg.scale_y <= SCALE_W'(65536);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ENABLE:  r_cfg.enable  <= i_cfg.data[0];
                REG_OVL_W:   r_cfg.ovl_w   <= i_cfg.data[OVL_DIM_W-1:0];
                REG_OVL_H:   r_cfg.ovl_h   <= i_cfg.data[OVL_DIM_W-1:0];
                REG_OUT_W:   r_cfg.out_w   <= i_cfg.data[OUT_DIM_W-1:0];
                REG_OUT_H:   r_cfg.out_h   <= i_cfg.data[OUT_DIM_W-1:0];
                REG_SCALE_X: r_cfg.scale_x <= i_cfg.data[SCALE_W-1:0];
                REG_SCALE_Y: r_cfg.scale_y <= i_cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    logic               f_valid, f_ready;
    logic [ENTRY_W-1:0] f_entry;
    logic               q_valid, q_ready;
    logic [ENTRY_W-1:0] q_entry;

    ovab_front #(
        .MAX_OVL_WIDTH  (MAX_OVL_WIDTH),
        .MAX_OVL_HEIGHT (MAX_OVL_HEIGHT),
        .FRAC_BITS      (FRAC_BITS),
        .ENTRY_W        (ENTRY_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_pix.valid),
        .i_opcode (i_pix.opcode),
        .i_pos_x  (i_pix.pos_x),
        .i_pos_y  (i_pix.pos_y),
        .i_red    (i_pix.red_in),
        .i_green  (i_pix.green_in),
        .i_blue   (i_pix.blue_in),
        .i_alpha  (i_pix.alpha_in),
        .o_ready  (i_pix.ready),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_entry  (f_entry)
    );

    ovab_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_entry),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_entry)
    );

    ovab_back #(
        .MAX_OVL_WIDTH  (MAX_OVL_WIDTH),
        .MAX_OVL_HEIGHT (MAX_OVL_HEIGHT),
        .FRAC_BITS      (FRAC_BITS),
        .ENTRY_W        (ENTRY_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_entry (q_entry),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_red   (o_res.red_out),
        .o_green (o_res.green_out),
        .o_blue  (o_res.blue_out)
    );

endmodule
`default_nettype wire
